// ----- hw/rtl/lebuf_pkg.sv -----
// Shared constants, key codes and controller/datapath link types for the line edit buffer.
// No dependencies.
`timescale 1ns / 1ps

package lebuf_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

    localparam logic [LEN_W-1:0] LEN_ZERO = '0;
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO  = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(LINE_CAPACITY);

    // plain key bytes
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_ENTER     = 8'd13;
    localparam logic [7:0] KEY_ESCAPE    = 8'd27;
    localparam logic [7:0] KEY_PREFIX    = 8'd224;

    // extended scan codes
    localparam logic [7:0] SC_HOME   = 8'd71;
    localparam logic [7:0] SC_UP     = 8'd72;
    localparam logic [7:0] SC_LEFT   = 8'd75;
    localparam logic [7:0] SC_RIGHT  = 8'd77;
    localparam logic [7:0] SC_END    = 8'd79;
    localparam logic [7:0] SC_DOWN   = 8'd80;
    localparam logic [7:0] SC_INSERT = 8'd82;
    localparam logic [7:0] SC_DELETE = 8'd83;

    typedef struct packed {
        logic load_key;
        logic advance;
    } leb_cmd_t;

    typedef struct packed {
        logic start_emit;
        logic emit_last;
    } leb_stat_t;

endpackage

// ----- hw/rtl/lebuf_datapath.sv -----
// Line store, cursor/length/mode registers, key decode and result register.
// Depends on lebuf_pkg.
`timescale 1ns / 1ps

module lebuf_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   key_code,
    input  logic                         extended,
    input  lebuf_pkg::leb_cmd_t          cmd,
    output lebuf_pkg::leb_stat_t         stat,
    output logic                         result_kind,
    output logic [7:0]                   char_value,
    output logic [5:0]                   cursor_pos,
    output logic [5:0]                   line_length,
    output logic                         insert_mode,
    output logic                         last
);

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE
    } store_op_t;

    logic [7:0]                  store_reg [lebuf_pkg::LINE_CAPACITY];
    logic [lebuf_pkg::LEN_W-1:0] cursor_reg, cursor_next;
    logic [lebuf_pkg::LEN_W-1:0] length_reg, length_next;
    logic                        insert_reg, insert_next;
    logic [lebuf_pkg::LEN_W-1:0] rem_reg, rem_next;

    logic                        kind_reg, kind_next;
    logic [7:0]                  char_reg, char_next;
    logic [lebuf_pkg::LEN_W-1:0] ocur_reg, ocur_next;
    logic [lebuf_pkg::LEN_W-1:0] olen_reg, olen_next;
    logic                        mode_reg, mode_next;
    logic                        last_reg, last_next;

    store_op_t                   op;
    logic [lebuf_pkg::LEN_W-1:0] pos;
    logic                        enter_fill;

    assign enter_fill = !extended && (key_code == lebuf_pkg::KEY_ENTER)
                        && (length_reg != lebuf_pkg::LEN_ZERO);

    assign stat.start_emit = enter_fill;
    assign stat.emit_last  = (rem_reg == lebuf_pkg::LEN_ONE);

    always_comb
    begin
        cursor_next = cursor_reg;
        length_next = length_reg;
        insert_next = insert_reg;
        rem_next    = rem_reg;
        op          = OP_HOLD;
        pos         = cursor_reg;
        kind_next   = kind_reg;
        char_next   = char_reg;
        ocur_next   = ocur_reg;
        olen_next   = olen_reg;
        mode_next   = mode_reg;
        last_next   = last_reg;

        if (cmd.load_key)
        begin
            if (extended)
            begin
                case (key_code)
                    lebuf_pkg::SC_HOME, lebuf_pkg::SC_DOWN:
                        cursor_next = lebuf_pkg::LEN_ZERO;
                    lebuf_pkg::SC_END, lebuf_pkg::SC_UP:
                        cursor_next = length_reg;
                    lebuf_pkg::SC_LEFT:
                        if (cursor_reg != lebuf_pkg::LEN_ZERO)
                            cursor_next = cursor_reg - lebuf_pkg::LEN_ONE;
                    lebuf_pkg::SC_RIGHT:
                        if (cursor_reg < length_reg)
                            cursor_next = cursor_reg + lebuf_pkg::LEN_ONE;
                    lebuf_pkg::SC_DELETE:
                        if (cursor_reg < length_reg)
                        begin
                            op          = OP_REMOVE;
                            pos         = cursor_reg;
                            length_next = length_reg - lebuf_pkg::LEN_ONE;
                        end
                    lebuf_pkg::SC_INSERT:
                        insert_next = ~insert_reg;
                    default:
                        ;
                endcase
            end
            else
            begin
                case (key_code)
                    lebuf_pkg::KEY_ENTER:
                        if (length_reg != lebuf_pkg::LEN_ZERO)
                        begin
                            cursor_next = lebuf_pkg::LEN_ZERO;
                            length_next = lebuf_pkg::LEN_ZERO;
                        end
                    lebuf_pkg::KEY_BACKSPACE:
                        if (cursor_reg != lebuf_pkg::LEN_ZERO)
                        begin
                            cursor_next = cursor_reg - lebuf_pkg::LEN_ONE;
                            op          = OP_REMOVE;
                            pos         = cursor_reg - lebuf_pkg::LEN_ONE;
                            length_next = length_reg - lebuf_pkg::LEN_ONE;
                        end
                    lebuf_pkg::KEY_ESCAPE:
                    begin
                        cursor_next = lebuf_pkg::LEN_ZERO;
                        length_next = lebuf_pkg::LEN_ZERO;
                    end
                    lebuf_pkg::KEY_PREFIX:
                        ;
                    default:
                        if (!insert_reg)
                        begin
                            if (cursor_reg < lebuf_pkg::LEN_CAP)
                            begin
                                op          = OP_WRITE;
                                cursor_next = cursor_reg + lebuf_pkg::LEN_ONE;
                                if (cursor_reg == length_reg)
                                    length_next = length_reg + lebuf_pkg::LEN_ONE;
                            end
                        end
                        else if (length_reg < lebuf_pkg::LEN_CAP)
                        begin
                            op          = OP_INSERT;
                            cursor_next = cursor_reg + lebuf_pkg::LEN_ONE;
                            length_next = length_reg + lebuf_pkg::LEN_ONE;
                        end
                endcase
            end

            kind_next = enter_fill;
            char_next = enter_fill ? store_reg[0] : 8'd0;
            ocur_next = cursor_next;
            olen_next = length_next;
            mode_next = insert_next;
            last_next = enter_fill ? (length_reg == lebuf_pkg::LEN_ONE) : 1'b1;
            rem_next  = length_reg;
        end
        else if (cmd.advance)
        begin
            // emission walks the line out of entry 0
            op        = OP_REMOVE;
            pos       = lebuf_pkg::LEN_ZERO;
            char_next = store_reg[1];
            last_next = (rem_reg == lebuf_pkg::LEN_TWO);
            rem_next  = rem_reg - lebuf_pkg::LEN_ONE;
        end
    end

    for (genvar i = 0; i < lebuf_pkg::LINE_CAPACITY; i++)
    begin : g_entry
        localparam logic [lebuf_pkg::LEN_W-1:0] POS = lebuf_pkg::LEN_W'(i);
        logic [7:0] prev_char;
        logic [7:0] succ_char;
        logic [7:0] entry_next;

        if (i > 0)
        begin : g_prev
            assign prev_char = store_reg[i-1];
        end
        else
        begin : g_prev0
            assign prev_char = store_reg[i];
        end

        if (i < lebuf_pkg::LINE_CAPACITY - 1)
        begin : g_succ
            assign succ_char = store_reg[i+1];
        end
        else
        begin : g_succ_end
            assign succ_char = store_reg[i];
        end

        always_comb
        begin
            entry_next = store_reg[i];
            case (op)
                OP_WRITE:
                    if (POS == pos)
                        entry_next = key_code;
                OP_INSERT:
                    if (POS == pos)
                        entry_next = key_code;
                    else if (POS > pos)
                        entry_next = prev_char;
                OP_REMOVE:
                    if (POS >= pos)
                        entry_next = succ_char;
                default:
                    ;
            endcase
        end

        always_ff @(posedge clk)
        begin
            store_reg[i] <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= lebuf_pkg::LEN_ZERO;
            length_reg <= lebuf_pkg::LEN_ZERO;
            insert_reg <= 1'b0;
            rem_reg    <= lebuf_pkg::LEN_ZERO;
        end
        else
        begin
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            insert_reg <= insert_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        ocur_reg <= ocur_next;
        olen_reg <= olen_next;
        mode_reg <= mode_next;
        last_reg <= last_next;
    end

    assign result_kind = kind_reg;
    assign char_value  = char_reg;
    assign cursor_pos  = 6'(ocur_reg);
    assign line_length = 6'(olen_reg);
    assign insert_mode = mode_reg;
    assign last        = last_reg;

endmodule

// ----- hw/rtl/lebuf_ctrl.sv -----
// Controller: key/result handshakes and sequencing of status and line emission beats.
// Depends on lebuf_pkg.
`timescale 1ns / 1ps

module lebuf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    output logic                  key_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    input  lebuf_pkg::leb_stat_t  stat,
    output lebuf_pkg::leb_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STATUS,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   key_take;

    // a new key may land on the edge that takes the final result beat
    always_comb
    begin
        case (state_reg)
            S_IDLE:   key_ready = 1'b1;
            S_STATUS: key_ready = res_ready;
            S_EMIT:   key_ready = res_ready && stat.emit_last;
            default:  key_ready = 1'b0;
        endcase
    end

    assign key_take = key_valid && key_ready;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        cmd.load_key   = key_take;
        cmd.advance    = 1'b0;

        if (key_take)
        begin
            state_next     = stat.start_emit ? S_EMIT : S_STATUS;
            res_valid_next = 1'b1;
        end
        else
        begin
            case (state_reg)
                S_STATUS:
                    if (res_ready)
                    begin
                        state_next     = S_IDLE;
                        res_valid_next = 1'b0;
                    end
                S_EMIT:
                    if (res_ready)
                    begin
                        if (stat.emit_last)
                        begin
                            state_next     = S_IDLE;
                            res_valid_next = 1'b0;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ----- hw/rtl/line_edit_buffer_unit.sv -----
// Top level of the line edit buffer: controller plus datapath.
// Depends on lebuf_pkg, lebuf_ctrl, lebuf_datapath.
//
//   channel | handshake             | payload
//   key     | key_valid / key_ready | key_code, extended
//   result  | res_valid / res_ready | result_kind, char_value, cursor_pos,
//           |                       | line_length, insert_mode, last
//
// A key is decoded and applied in the cycle it is accepted; its status beat
// is registered and shows the next cycle. Enter on a non-empty line emits one
// beat per held character (up to LINE_CAPACITY beats), shifted out of entry 0.
// A new key is taken on the same edge that takes the final result beat.
// Reset clears cursor, length and mode; line contents are undefined until written.
`timescale 1ns / 1ps

module line_edit_buffer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_ready,
    input  logic [7:0] key_code,
    input  logic       extended,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       result_kind,
    output logic [7:0] char_value,
    output logic [5:0] cursor_pos,
    output logic [5:0] line_length,
    output logic       insert_mode,
    output logic       last
);

    lebuf_pkg::leb_cmd_t  cmd;
    lebuf_pkg::leb_stat_t stat;

    lebuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lebuf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_code    (key_code),
        .extended    (extended),
        .cmd         (cmd),
        .stat        (stat),
        .result_kind (result_kind),
        .char_value  (char_value),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .insert_mode (insert_mode),
        .last        (last)
    );

endmodule

// ----- tb/line_edit_buffer_unit_test.sv -----
// Self-checking testbench for line_edit_buffer_unit: directed key sequences, full-line cases
// and random edit sessions under varying idle/stall, checked against an in-bench editor model.
// Depends on lebuf_pkg and line_edit_buffer_unit.
`timescale 1ns / 1ps

module line_edit_buffer_unit_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [5:0] cur;
        logic [5:0] len;
        logic       ins;
        logic       last;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       key_valid = 1'b0;
    logic       key_ready;
    logic [7:0] key_code = 8'd0;
    logic       extended = 1'b0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic       result_kind;
    logic [7:0] char_value;
    logic [5:0] cursor_pos;
    logic [5:0] line_length;
    logic       insert_mode;
    logic       last;

    // editor model state
    logic [7:0] line_chars [0:lebuf_pkg::LINE_CAPACITY-1];
    logic [5:0] edit_cursor = '0;
    logic [5:0] edit_length = '0;
    logic       edit_insert = 1'b0;

    beat_t pending_beats [$];
    int    errors = 0;
    int    keys_sent = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    cycles = 0;

    line_edit_buffer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_ready   (key_ready),
        .key_code    (key_code),
        .extended    (extended),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .result_kind (result_kind),
        .char_value  (char_value),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .insert_mode (insert_mode),
        .last        (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic drop_char_at(input logic [5:0] pos);
        int i;
        for (i = pos; i + 1 < edit_length; i++)
            line_chars[i] = line_chars[i + 1];
        edit_length = edit_length - 6'd1;
    endtask

    task automatic push_status();
        beat_t b;
        b = '{kind: 1'b0, ch: 8'd0, cur: edit_cursor, len: edit_length,
              ins: edit_insert, last: 1'b1};
        pending_beats.push_back(b);
    endtask

    task automatic apply_key(input logic [7:0] code, input logic ext);
        int    i;
        int    n;
        beat_t b;
        if (ext)
        begin
            case (code)
                lebuf_pkg::SC_HOME, lebuf_pkg::SC_DOWN: edit_cursor = '0;
                lebuf_pkg::SC_END, lebuf_pkg::SC_UP:    edit_cursor = edit_length;
                lebuf_pkg::SC_LEFT:
                    if (edit_cursor > 0) edit_cursor = edit_cursor - 6'd1;
                lebuf_pkg::SC_RIGHT:
                    if (edit_cursor < edit_length) edit_cursor = edit_cursor + 6'd1;
                lebuf_pkg::SC_DELETE:
                    if (edit_cursor < edit_length) drop_char_at(edit_cursor);
                lebuf_pkg::SC_INSERT: edit_insert = ~edit_insert;
                default: ;
            endcase
            push_status();
        end
        else if (code == lebuf_pkg::KEY_ENTER && edit_length > 0)
        begin
            n = edit_length;
            edit_cursor = '0;
            edit_length = '0;
            for (i = 0; i < n; i++)
            begin
                b = '{kind: 1'b1, ch: line_chars[i], cur: 6'd0, len: 6'd0,
                      ins: edit_insert, last: (i == n - 1)};
                pending_beats.push_back(b);
            end
        end
        else
        begin
            case (code)
                lebuf_pkg::KEY_ENTER, lebuf_pkg::KEY_PREFIX: ;
                lebuf_pkg::KEY_BACKSPACE:
                    if (edit_cursor > 0)
                    begin
                        edit_cursor = edit_cursor - 6'd1;
                        drop_char_at(edit_cursor);
                    end
                lebuf_pkg::KEY_ESCAPE:
                begin
                    edit_cursor = '0;
                    edit_length = '0;
                end
                default:
                    if (!edit_insert)
                    begin
                        if (edit_cursor < lebuf_pkg::LINE_CAPACITY)
                        begin
                            line_chars[edit_cursor] = code;
                            if (edit_cursor == edit_length)
                                edit_length = edit_length + 6'd1;
                            edit_cursor = edit_cursor + 6'd1;
                        end
                    end
                    else if (edit_length < lebuf_pkg::LINE_CAPACITY)
                    begin
                        for (i = edit_length; i > edit_cursor; i--)
                            line_chars[i] = line_chars[i - 1];
                        line_chars[edit_cursor] = code;
                        edit_cursor = edit_cursor + 6'd1;
                        edit_length = edit_length + 6'd1;
                    end
            endcase
            push_status();
        end
    endtask

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_key(input logic [7:0] code, input logic ext);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_code  <= code;
        extended  <= ext;
        @(posedge clk);
        while (!key_ready)
            @(posedge clk);
        apply_key(code, ext);
        keys_sent++;
    endtask

    function automatic logic [7:0] any_printable();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == lebuf_pkg::KEY_ENTER || c == lebuf_pkg::KEY_BACKSPACE
               || c == lebuf_pkg::KEY_ESCAPE || c == lebuf_pkg::KEY_PREFIX);
        return c;
    endfunction

    task automatic compare_field(input string what, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        beat_t want;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (pending_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual kind %0d char %0d",
                             $time, result_kind, char_value);
                end
                else
                begin
                    want = pending_beats.pop_front();
                    compare_field("result_kind", 8'(want.kind), 8'(result_kind));
                    compare_field("char_value", want.ch, char_value);
                    compare_field("cursor_pos", 8'(want.cur), 8'(cursor_pos));
                    compare_field("line_length", 8'(want.len), 8'(line_length));
                    compare_field("insert_mode", 8'(want.ins), 8'(insert_mode));
                    compare_field("last", 8'(want.last), 8'(last));
                end
            end
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed_keys();
        send_key(8'd65, 1'b0);
        send_key(8'd0, 1'b0);
        send_key(8'd255, 1'b0);
        send_key(8'd255, 1'b1);
        send_key(8'd0, 1'b1);
        send_key(lebuf_pkg::KEY_PREFIX, 1'b0);
        send_key(lebuf_pkg::SC_LEFT, 1'b1);
        send_key(lebuf_pkg::SC_HOME, 1'b1);
        send_key(lebuf_pkg::SC_LEFT, 1'b1);
        send_key(lebuf_pkg::KEY_BACKSPACE, 1'b0);
        send_key(lebuf_pkg::SC_END, 1'b1);
        send_key(lebuf_pkg::SC_RIGHT, 1'b1);
        send_key(lebuf_pkg::SC_DELETE, 1'b1);
        send_key(lebuf_pkg::SC_DOWN, 1'b1);
        send_key(lebuf_pkg::SC_RIGHT, 1'b1);
        send_key(lebuf_pkg::SC_INSERT, 1'b1);
        send_key(8'd120, 1'b0);
        send_key(lebuf_pkg::SC_DELETE, 1'b1);
        send_key(lebuf_pkg::SC_UP, 1'b1);
        send_key(lebuf_pkg::KEY_BACKSPACE, 1'b0);
        send_key(lebuf_pkg::SC_INSERT, 1'b1);
        send_key(lebuf_pkg::SC_HOME, 1'b1);
        send_key(8'd75, 1'b0);
        // command bytes with the extended flag, then without it
        send_key(lebuf_pkg::KEY_ENTER, 1'b1);
        send_key(lebuf_pkg::KEY_ESCAPE, 1'b1);
        send_key(lebuf_pkg::KEY_ENTER, 1'b0);
        send_key(lebuf_pkg::KEY_ENTER, 1'b0);
        send_key(8'd66, 1'b0);
        send_key(lebuf_pkg::KEY_ESCAPE, 1'b0);
    endtask

    task automatic test_full_line();
        int i;
        if (edit_insert)
            send_key(lebuf_pkg::SC_INSERT, 1'b1);
        send_key(lebuf_pkg::KEY_ESCAPE, 1'b0);
        for (i = 0; i <= lebuf_pkg::LINE_CAPACITY; i++)
            send_key(any_printable(), 1'b0);
        send_key(lebuf_pkg::SC_LEFT, 1'b1);
        send_key(any_printable(), 1'b0);
        send_key(lebuf_pkg::SC_INSERT, 1'b1);
        send_key(any_printable(), 1'b0);
        send_key(lebuf_pkg::SC_HOME, 1'b1);
        send_key(lebuf_pkg::SC_DELETE, 1'b1);
        send_key(any_printable(), 1'b0);
        send_key(any_printable(), 1'b0);
        send_key(lebuf_pkg::KEY_ENTER, 1'b0);
        send_key(lebuf_pkg::SC_INSERT, 1'b1);
    endtask

    task automatic random_session();
        int n;
        int k;
        int pick;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 10);
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_key(any_printable(), 1'b0);
            else if (pick < 90)
            begin
                case ($urandom_range(0, 8))
                    0: send_key(lebuf_pkg::SC_HOME, 1'b1);
                    1: send_key(lebuf_pkg::SC_END, 1'b1);
                    2: send_key(lebuf_pkg::SC_LEFT, 1'b1);
                    3: send_key(lebuf_pkg::SC_RIGHT, 1'b1);
                    4: send_key(lebuf_pkg::SC_DELETE, 1'b1);
                    5: send_key(lebuf_pkg::SC_INSERT, 1'b1);
                    6: send_key(lebuf_pkg::SC_UP, 1'b1);
                    7: send_key(lebuf_pkg::SC_DOWN, 1'b1);
                    default: send_key(lebuf_pkg::KEY_BACKSPACE, 1'b0);
                endcase
            end
            else
                send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) == 0)
            send_key(lebuf_pkg::KEY_ESCAPE, 1'b0);
        else
            send_key(lebuf_pkg::KEY_ENTER, 1'b0);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = keys_sent;
        while (keys_sent - start < count)
            random_session();
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 25);
        random_phase(60, 0, 25);
        random_phase(0, 60, 25);
        random_phase(35, 35, 25);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_keys();
        test_full_line();
        test_random_traffic();
        key_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (lebuf_pkg::LINE_CAPACITY + 8) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            errors++;
            $display("%0t: result beats missing, expected %0d more, actual 0",
                     $time, pending_beats.size());
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
